// ===== design/sle_pkg.sv =====
// Shared types, codes and constants for the serial line editor.
`timescale 1ns / 1ps

package sle_pkg;

  // Default depth of the line store
  localparam int LINE_MAX_DEF = 64;

  // Reset value of the line limit register
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Input commands
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Job operations handed from the editor to the emitter
  localparam logic [1:0] OP_ECHO = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_BS   = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [5:0] line_length;
    logic       last;
  } out_item_t;

  // One accepted item that produces results
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       hit;
    logic [5:0] length;
  } job_t;

endpackage

// ===== design/sle_store.sv =====
// Line store: single write port, registered read port.
`timescale 1ns / 1ps

module sle_store #(
  parameter int LINE_MAX = sle_pkg::LINE_MAX_DEF,
  parameter int CW       = $clog2(LINE_MAX)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [CW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [CW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [LINE_MAX];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sle_edit.sv =====
// Edit state: decodes accepted items, tracks counts, drives the line store.
`timescale 1ns / 1ps

module sle_edit #(
  parameter int LINE_MAX = sle_pkg::LINE_MAX_DEF,
  parameter int CW       = $clog2(LINE_MAX)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  sle_pkg::in_item_t item,
  input  logic [6:0]       line_limit,
  output logic             job_valid,
  output sle_pkg::job_t    job,
  output logic             mem_we,
  output logic [CW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic             mem_re,
  output logic [CW-1:0]    mem_raddr
);

  // Compare widths
  localparam int EW = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int IW = (CW > 6) ? CW : 6;

  logic [CW-1:0] edit_count, edit_count_next;
  logic [CW-1:0] done_length, done_length_next;

  logic [EW-1:0] lim_e, max_e, cap;
  logic          room, is_eol, is_bs, is_print, read_hit;
  logic [IW-1:0] idx_w;

  // Capacity = min(limit, LINE_MAX) - 1, room while count + 1 < capacity + 1
  always_comb begin
    lim_e = EW'(line_limit);
    max_e = EW'(LINE_MAX);
    cap   = (lim_e > max_e) ? max_e : lim_e;
    room  = (EW'(edit_count) + EW'(1)) < cap;
  end

  // Byte classes
  assign is_eol   = (item.rx_byte == sle_pkg::CH_CR) || (item.rx_byte == sle_pkg::CH_LF);
  assign is_bs    = (item.rx_byte == sle_pkg::CH_BS) || (item.rx_byte == sle_pkg::CH_DEL);
  assign is_print = (item.rx_byte >= sle_pkg::CH_SPACE) && (item.rx_byte <= sle_pkg::CH_TILDE);

  // Read lookup
  assign idx_w     = IW'(item.read_index);
  assign read_hit  = (idx_w < IW'(done_length)) && (EW'(item.read_index) < max_e);
  assign mem_raddr = idx_w[CW-1:0];
  assign mem_re    = accept && (item.cmd == sle_pkg::CMD_READ);

  // Store write for appended bytes
  assign mem_waddr = edit_count;
  assign mem_wdata = item.rx_byte;

  // Decode and next state
  always_comb begin
    edit_count_next  = edit_count;
    done_length_next = done_length;
    job_valid        = 1'b0;
    mem_we           = 1'b0;
    job.op           = sle_pkg::OP_ECHO;
    job.data         = item.rx_byte;
    job.hit          = read_hit;
    job.length       = 6'(edit_count);
    if (accept) begin
      if (item.cmd == sle_pkg::CMD_READ) begin
        job_valid = 1'b1;
        job.op    = sle_pkg::OP_READ;
      end else if (is_eol) begin
        job_valid        = 1'b1;
        job.op           = sle_pkg::OP_EOL;
        done_length_next = edit_count;
        edit_count_next  = '0;
      end else if (is_bs) begin
        if (edit_count != '0) begin
          job_valid       = 1'b1;
          job.op          = sle_pkg::OP_BS;
          edit_count_next = edit_count - CW'(1);
        end
      end else if (is_print && room) begin
        job_valid       = 1'b1;
        job.op          = sle_pkg::OP_ECHO;
        mem_we          = 1'b1;
        edit_count_next = edit_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_count  <= '0;
      done_length <= '0;
    end else begin
      edit_count  <= edit_count_next;
      done_length <= done_length_next;
    end
  end

  // Line end always clears the count
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == sle_pkg::CMD_RX && is_eol) |=> (edit_count == '0))
    else $error("edit count not cleared after line end");

  // Completed length moves only on a line end
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && item.cmd == sle_pkg::CMD_RX && is_eol) |=> $stable(done_length))
    else $error("completed length changed without line end");

  // Store writes only for echoed bytes
  a_write_echo: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (job_valid && job.op == sle_pkg::OP_ECHO))
    else $error("store write without echo");

endmodule

// ===== design/sle_emit.sv =====
// Result emitter: holds one job and sends its results through an output register.
`timescale 1ns / 1ps

module sle_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  sle_pkg::job_t      job,
  input  logic [7:0]         rdata,
  output logic               busy,
  output logic               result_valid,
  input  logic               result_stall,
  output sle_pkg::out_item_t result
);

  logic               s1_valid;
  sle_pkg::job_t      s1_job;
  logic [1:0]         s1_phase;
  sle_pkg::out_item_t gen;
  logic               out_load;

  // Result for the current job and phase
  always_comb begin
    gen.kind        = sle_pkg::KIND_ECHO;
    gen.out_byte    = s1_job.data;
    gen.line_length = '0;
    gen.last        = 1'b1;
    case (s1_job.op)
      sle_pkg::OP_ECHO: begin
        gen.last = 1'b1;
      end
      sle_pkg::OP_READ: begin
        gen.kind     = sle_pkg::KIND_READ;
        gen.out_byte = s1_job.hit ? rdata : 8'h00;
      end
      sle_pkg::OP_EOL: begin
        case (s1_phase)
          2'd0: begin
            gen.out_byte = sle_pkg::CH_CR;
            gen.last     = 1'b0;
          end
          2'd1: begin
            gen.out_byte = sle_pkg::CH_LF;
            gen.last     = 1'b0;
          end
          default: begin
            gen.kind        = sle_pkg::KIND_DONE;
            gen.out_byte    = 8'h00;
            gen.line_length = s1_job.length;
          end
        endcase
      end
      default: begin
        // backspace, space, backspace
        gen.out_byte = (s1_phase == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
        gen.last     = (s1_phase == 2'd2);
      end
    endcase
  end

  assign out_load = s1_valid && (!result_valid || !result_stall);
  assign busy     = s1_valid && !(out_load && gen.last);

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 2'd0;
    end else if (job_valid) begin
      s1_valid <= 1'b1;
      s1_phase <= 2'd0;
    end else if (out_load && gen.last) begin
      s1_valid <= 1'b0;
      s1_phase <= 2'd0;
    end else if (out_load) begin
      s1_phase <= s1_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      s1_job <= job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= gen;
    end
  end

  // A new job only lands when the held one sends its final result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (job_valid && s1_valid) |-> (out_load && gen.last))
    else $error("job overwritten before completion");

  // Single-result jobs never advance past the first phase
  a_single_phase: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_job.op == sle_pkg::OP_ECHO || s1_job.op == sle_pkg::OP_READ))
      |-> (s1_phase == 2'd0))
    else $error("single-result job past first phase");

  // Line complete is always the final result
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == sle_pkg::KIND_DONE) |-> result.last)
    else $error("line complete not marked last");

endmodule

// ===== design/serial_line_editor.sv =====
// Top level of the serial line editor.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   item     | in        | item_valid/item_stall | sle_pkg::in_item_t
//   result   | out       | result_valid/stall    | sle_pkg::out_item_t
//   cfg      | in        | cfg_valid/cfg_ready   | line limit, 7 bits
//
// After an item that gives one result (printable echo, read), a new item can
// be taken every cycle unless result_stall holds back a result. Line end and
// backspace give three results and stall new items until the last is sent.
// Results pass the job register, then the output register; read data comes
// from the registered store port as the item is taken. Reset is synchronous
// and needs no clearing pass; item_stall is up until a job's last result goes.
`timescale 1ns / 1ps

module serial_line_editor #(
  parameter int LINE_MAX = sle_pkg::LINE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sle_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output sle_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam int CW = $clog2(LINE_MAX);

  logic          accept;
  logic [6:0]    line_limit;
  logic          job_valid;
  sle_pkg::job_t job;
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= sle_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_limit <= cfg_data;
    end
  end

  assign accept = item_valid && !item_stall;

  sle_edit #(
    .LINE_MAX (LINE_MAX),
    .CW       (CW)
  ) u_edit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .line_limit (line_limit),
    .job_valid  (job_valid),
    .job        (job),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  sle_store #(
    .LINE_MAX (LINE_MAX),
    .CW       (CW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sle_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .rdata        (mem_rdata),
    .busy         (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
